// File: sv/hid_boot_report_to_scancode_events_top_assert.svh
// assertion macros shared by the scancode event generator modules
`ifndef HID_BOOT_REPORT_TO_SCANCODE_EVENTS_TOP_ASSERT_SVH
`define HID_BOOT_REPORT_TO_SCANCODE_EVENTS_TOP_ASSERT_SVH

// property must hold on every clock edge out of reset
`define HBRSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// condition must never be seen on a clock edge out of reset
`define HBRSE_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error(msg);

`endif

// File: sv/hbrse_pkg.sv
// shared constants, tables and helpers of the scancode event generator
package hbrse_pkg;

  localparam int unsigned KEY_SLOTS_DEF   = 6;
  localparam int unsigned INPUT_SLOTS     = 6;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;
  localparam int unsigned USAGE_COUNT     = 53;

  localparam logic [7:0] USAGE_FIRST    = 8'h04;
  localparam logic [7:0] USAGE_LAST     = 8'h38;
  localparam logic [7:0] USAGE_ROLLOVER = 8'h01;
  localparam logic [7:0] UNMAPPED_MOD   = 8'h80;

  localparam logic [2:0] MOD_RCTRL = 3'd4;
  localparam logic [2:0] MOD_RALT  = 3'd6;

  localparam logic [7:0] USAGE_TABLE [USAGE_COUNT] = '{
    8'h1e, 8'h30, 8'h2e, 8'h20, 8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
    8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14, 8'h16, 8'h2f, 8'h11, 8'h2d,
    8'h15, 8'h2c, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
    8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'h0c, 8'h0d, 8'h1a, 8'h1b, 8'h2b, 8'h00, 8'h27,
    8'h28, 8'h29, 8'h33, 8'h34, 8'h35
  };

  localparam logic [7:0] MOD_TABLE [8] = '{
    8'h1d, 8'h2a, 8'h38, 8'h00, 8'h1d, 8'h36, 8'h38, 8'h00
  };

  // job layout, lowest bits first: new modifiers, modifier change mask,
  // old keys, new keys, release mask, press mask
  function automatic int unsigned job_w(int unsigned key_slots);
    return 16 + 18 * key_slots;
  endfunction

  // zero when the usage has no set-1 code
  function automatic logic [7:0] usage_scancode(logic [7:0] usage);
    logic [7:0] code;
    code = '0;
    if (usage >= USAGE_FIRST && usage <= USAGE_LAST) begin
      code = USAGE_TABLE[6'(usage - USAGE_FIRST)];
    end
    return code;
  endfunction

endpackage

// File: sv/hbrse_front.sv
// report intake: length masking, rollover filter, diff against the stored report
module hbrse_front #(
  parameter int unsigned KEY_SLOTS = hbrse_pkg::KEY_SLOTS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic                                     transfer_ok_i,
  input  logic [3:0]                               report_length_i,
  input  logic [7:0]                               modifier_bits_i,
  input  logic [7:0]                               key_slot_a_i,
  input  logic [7:0]                               key_slot_b_i,
  input  logic [7:0]                               key_slot_c_i,
  input  logic [7:0]                               key_slot_d_i,
  input  logic [7:0]                               key_slot_e_i,
  input  logic [7:0]                               key_slot_f_i,
  input  logic                                     queue_full_i,
  output logic                                     push_o,
  output logic [hbrse_pkg::job_w(KEY_SLOTS)-1:0]   job_o
);
  import hbrse_pkg::*;

  localparam int unsigned JobW = job_w(KEY_SLOTS);

  logic [7:0]           key_in [INPUT_SLOTS];
  logic [7:0]           slots  [KEY_SLOTS];
  logic [7:0]           mods;
  logic                 rollover;
  logic [KEY_SLOTS-1:0] rel_mask;
  logic [KEY_SLOTS-1:0] prs_mask;
  logic [7:0]           mod_diff;
  logic                 accept;
  logic                 store;

  logic [7:0] prior_mod_q, prior_mod_d;
  logic [7:0] prior_keys_q [KEY_SLOTS];

  assign key_in[0] = key_slot_a_i;
  assign key_in[1] = key_slot_b_i;
  assign key_in[2] = key_slot_c_i;
  assign key_in[3] = key_slot_d_i;
  assign key_in[4] = key_slot_e_i;
  assign key_in[5] = key_slot_f_i;

  assign mods = (report_length_i >= 4'd1) ? modifier_bits_i : '0;

  // key slot i sits at report byte i+2
  for (genvar g = 0; g < KEY_SLOTS; g++) begin : g_slot
    if (g < INPUT_SLOTS) begin : g_in
      assign slots[g] = (report_length_i >= 4'(g + 3)) ? key_in[g] : '0;
    end else begin : g_zero
      assign slots[g] = '0;
    end
  end

  always_comb begin
    rollover = 1'b1;
    rel_mask = '0;
    prs_mask = '0;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      if (slots[i] != USAGE_ROLLOVER) rollover = 1'b0;
    end
    for (int i = 0; i < KEY_SLOTS; i++) begin
      rel_mask[i] = (prior_keys_q[i] != '0);
      prs_mask[i] = (slots[i] != '0);
      for (int j = 0; j < KEY_SLOTS; j++) begin
        if (slots[j] == prior_keys_q[i]) rel_mask[i] = 1'b0;
        if (prior_keys_q[j] == slots[i]) prs_mask[i] = 1'b0;
      end
    end
  end

  assign mod_diff    = mods ^ prior_mod_q;
  assign in_ready_o  = !queue_full_i;
  assign accept      = in_valid_i && in_ready_o;
  assign store       = accept && transfer_ok_i && !rollover;
  assign push_o      = store && ((|mod_diff) || (|rel_mask) || (|prs_mask));
  assign prior_mod_d = store ? mods : prior_mod_q;

  always_comb begin
    job_o = '0;
    job_o[7:0]  = mods;
    job_o[15:8] = mod_diff;
    for (int i = 0; i < KEY_SLOTS; i++) begin
      job_o[16 + 8*i +: 8]             = prior_keys_q[i];
      job_o[16 + 8*KEY_SLOTS + 8*i +: 8] = slots[i];
    end
    job_o[16 + 16*KEY_SLOTS +: KEY_SLOTS] = rel_mask;
    job_o[JobW-1 -: KEY_SLOTS]            = prs_mask;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_mod_q <= '0;
      for (int i = 0; i < KEY_SLOTS; i++) prior_keys_q[i] <= '0;
    end else begin
      prior_mod_q <= prior_mod_d;
      if (store) begin
        for (int i = 0; i < KEY_SLOTS; i++) prior_keys_q[i] <= slots[i];
      end
    end
  end

endmodule

// File: sv/hbrse_queue.sv
// short job queue between report intake and event output
module hbrse_queue #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = hbrse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output logic [WIDTH-1:0] data_o
);
  import hbrse_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_q [DEPTH];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_i, pop_i})
      2'b10:   count_d = count_q + CntW'(1);
      2'b01:   count_d = count_q - CntW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= push_data_i;
  end

  `include "hid_boot_report_to_scancode_events_top_assert.svh"

  `HBRSE_NEVER(a_no_push_full, push_i && full_o, "job pushed into a full queue")
  `HBRSE_NEVER(a_no_pop_empty, pop_i && !valid_o, "job popped from an empty queue")
  `HBRSE_ASSERT(a_count_range, count_q <= CntW'(DEPTH), "queue count beyond depth")

endmodule

// File: sv/hbrse_back.sv
// event sequencer: walks one job's change masks and emits one scancode item a cycle while out_ready_i allows
module hbrse_back #(
  parameter int unsigned KEY_SLOTS = hbrse_pkg::KEY_SLOTS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   job_valid_i,
  input  logic [hbrse_pkg::job_w(KEY_SLOTS)-1:0] job_i,
  output logic                                   job_pop_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic [7:0]                             scan_code_o,
  output logic                                   extended_prefix_o,
  output logic                                   unmapped_o,
  output logic                                   pressed_o,
  output logic                                   last_event_o
);
  import hbrse_pkg::*;

  localparam int unsigned JobW = job_w(KEY_SLOTS);
  localparam int unsigned IdxW = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

  // current job
  logic [7:0]           mod_new_q;
  logic [7:0]           mod_mask_q, mod_mask_d;
  logic [KEY_SLOTS-1:0] rel_mask_q, rel_mask_d;
  logic [KEY_SLOTS-1:0] prs_mask_q, prs_mask_d;
  logic [7:0]           old_key_q [KEY_SLOTS];
  logic [7:0]           new_key_q [KEY_SLOTS];

  // output register
  logic       out_valid_q, out_valid_d;
  logic [7:0] out_code_q;
  logic       out_ext_q, out_unm_q, out_prs_q, out_last_q;

  logic                 advance, have, emit, remaining, load, job_has_work;
  logic [2:0]           mod_idx;
  logic [IdxW-1:0]      rel_idx, prs_idx;
  logic [7:0]           mod_nx;
  logic [KEY_SLOTS-1:0] rel_nx, prs_nx;
  logic [7:0]           usage, key_code, mod_code;
  logic [7:0]           ev_code;
  logic                 ev_ext, ev_unm, ev_prs;

  assign advance   = !out_valid_q || out_ready_i;
  assign have      = (|mod_mask_q) || (|rel_mask_q) || (|prs_mask_q);
  assign emit      = advance && have;
  assign remaining = emit ? ((|mod_nx) || (|rel_nx) || (|prs_nx)) : have;
  assign load      = job_valid_i && !remaining;
  assign job_pop_o = load;

  assign job_has_work = (|job_i[15:8]) || (|job_i[JobW-1 -: 2*KEY_SLOTS]);

  // lowest set bit of each mask goes first
  always_comb begin
    mod_idx = '0;
    rel_idx = '0;
    prs_idx = '0;
    for (int i = 7; i >= 0; i--) begin
      if (mod_mask_q[i]) mod_idx = 3'(i);
    end
    for (int i = KEY_SLOTS - 1; i >= 0; i--) begin
      if (rel_mask_q[i]) rel_idx = IdxW'(i);
      if (prs_mask_q[i]) prs_idx = IdxW'(i);
    end
  end

  assign mod_code = MOD_TABLE[mod_idx];
  assign key_code = usage_scancode(usage);

  always_comb begin
    mod_nx  = mod_mask_q;
    rel_nx  = rel_mask_q;
    prs_nx  = prs_mask_q;
    usage   = '0;
    ev_code = '0;
    ev_ext  = 1'b0;
    ev_unm  = 1'b0;
    ev_prs  = 1'b0;
    priority if (|mod_mask_q) begin
      mod_nx = mod_mask_q & (mod_mask_q - 8'd1);
      ev_prs = mod_new_q[mod_idx];
      if (mod_code == '0) begin
        ev_code = UNMAPPED_MOD | {5'd0, mod_idx};
        ev_unm  = 1'b1;
      end else begin
        ev_code = mod_code;
        ev_ext  = (mod_idx == MOD_RCTRL) || (mod_idx == MOD_RALT);
      end
    end else if (|rel_mask_q) begin
      rel_nx  = rel_mask_q & (rel_mask_q - KEY_SLOTS'(1));
      usage   = old_key_q[rel_idx];
      ev_code = (key_code == '0) ? usage : key_code;
      ev_unm  = (key_code == '0);
    end else if (|prs_mask_q) begin
      prs_nx  = prs_mask_q & (prs_mask_q - KEY_SLOTS'(1));
      usage   = new_key_q[prs_idx];
      ev_code = (key_code == '0) ? usage : key_code;
      ev_unm  = (key_code == '0);
      ev_prs  = 1'b1;
    end else begin
      usage = '0;
    end
  end

  always_comb begin
    mod_mask_d  = emit ? mod_nx : mod_mask_q;
    rel_mask_d  = emit ? rel_nx : rel_mask_q;
    prs_mask_d  = emit ? prs_nx : prs_mask_q;
    out_valid_d = emit ? 1'b1 : (advance ? 1'b0 : out_valid_q);
    if (load) begin
      mod_mask_d = job_i[15:8];
      rel_mask_d = job_i[16 + 16*KEY_SLOTS +: KEY_SLOTS];
      prs_mask_d = job_i[JobW-1 -: KEY_SLOTS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_mask_q  <= '0;
      rel_mask_q  <= '0;
      prs_mask_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mod_mask_q  <= mod_mask_d;
      rel_mask_q  <= rel_mask_d;
      prs_mask_q  <= prs_mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      mod_new_q <= job_i[7:0];
      for (int i = 0; i < KEY_SLOTS; i++) begin
        old_key_q[i] <= job_i[16 + 8*i +: 8];
        new_key_q[i] <= job_i[16 + 8*KEY_SLOTS + 8*i +: 8];
      end
    end
    if (emit) begin
      out_code_q <= ev_code;
      out_ext_q  <= ev_ext;
      out_unm_q  <= ev_unm;
      out_prs_q  <= ev_prs;
      out_last_q <= !remaining;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign scan_code_o       = out_code_q;
  assign extended_prefix_o = out_ext_q;
  assign unmapped_o        = out_unm_q;
  assign pressed_o         = out_prs_q;
  assign last_event_o      = out_last_q;

  `include "hid_boot_report_to_scancode_events_top_assert.svh"

  `HBRSE_ASSERT(a_job_not_empty, load |-> job_has_work, "queued job carries no event")
  `HBRSE_ASSERT(a_run_continues, (out_valid_q && out_ready_i && !out_last_q) |=> out_valid_q, "event run broken before its last item")
  `HBRSE_NEVER(a_ext_is_mapped, out_valid_q && out_ext_q && out_unm_q, "extended prefix on an unmapped key")

endmodule

// File: sv/hid_boot_report_to_scancode_events_top.sv
// top level: usb boot keyboard reports in, set-1 scancode events out
// Each accepted report is compared with the last stored one and turns into a
// run of events: modifier changes (bit 0 upwards), then releases of keys gone,
// then presses of keys new, one item per unstalled cycle, the final item of
// the run marked by tlast. A run is 0 to 8 + 2*KEY_SLOTS items (20 for six
// slots); the output sequencer, at one event per cycle, sets the sustained
// rate. The intake diffs a report in the cycle it is accepted and parks the
// job in a QUEUE_DEPTH-entry queue, so new reports are taken while earlier
// runs are still being sent and s_axis_tready falls only when that queue is
// full. Failed transfers and ErrorRollOver reports give no events and leave
// the stored report as it was; a report that changes nothing is still stored.
module hid_boot_report_to_scancode_events_top #(
  parameter int unsigned KEY_SLOTS   = hbrse_pkg::KEY_SLOTS_DEF,
  parameter int unsigned QUEUE_DEPTH = hbrse_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // report_length[3:0], modifier_bits[11:4], key_slot_a[19:12] .. key_slot_f[59:52]
  input  logic [63:0] s_axis_tdata,
  // transfer_ok[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // scan_code[7:0]
  output logic [7:0]  m_axis_tdata,
  // extended_prefix[0], unmapped[1], pressed[2]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);
  import hbrse_pkg::*;

  localparam int unsigned JobW = job_w(KEY_SLOTS);

  logic            push, queue_full, job_valid, job_pop;
  logic [JobW-1:0] push_job, head_job;
  logic            ext, unm, prs;

  hbrse_front #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (s_axis_tvalid),
    .in_ready_o      (s_axis_tready),
    .transfer_ok_i   (s_axis_tuser),
    .report_length_i (s_axis_tdata[3:0]),
    .modifier_bits_i (s_axis_tdata[11:4]),
    .key_slot_a_i    (s_axis_tdata[19:12]),
    .key_slot_b_i    (s_axis_tdata[27:20]),
    .key_slot_c_i    (s_axis_tdata[35:28]),
    .key_slot_d_i    (s_axis_tdata[43:36]),
    .key_slot_e_i    (s_axis_tdata[51:44]),
    .key_slot_f_i    (s_axis_tdata[59:52]),
    .queue_full_i    (queue_full),
    .push_o          (push),
    .job_o           (push_job)
  );

  hbrse_queue #(
    .WIDTH (JobW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (queue_full),
    .pop_i       (job_pop),
    .valid_o     (job_valid),
    .data_o      (head_job)
  );

  hbrse_back #(
    .KEY_SLOTS (KEY_SLOTS)
  ) u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .job_valid_i       (job_valid),
    .job_i             (head_job),
    .job_pop_o         (job_pop),
    .out_valid_o       (m_axis_tvalid),
    .out_ready_i       (m_axis_tready),
    .scan_code_o       (m_axis_tdata),
    .extended_prefix_o (ext),
    .unmapped_o        (unm),
    .pressed_o         (prs),
    .last_event_o      (m_axis_tlast)
  );

  assign m_axis_tuser = {prs, unm, ext};

endmodule

// File: dv/scancode_event_checker.sv
// checker: predicts the scancode events of each accepted report and compares them
module scancode_event_checker
  import hbrse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  // report_length[3:0], modifier_bits[11:4], key_slot_a[19:12] .. key_slot_f[59:52]
  input  logic [63:0] s_tdata_i,
  // transfer_ok[0]
  input  logic        s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  // scan_code[7:0]
  input  logic [7:0]  m_tdata_i,
  // extended_prefix[0], unmapped[1], pressed[2]
  input  logic [2:0]  m_tuser_i,
  input  logic        m_tlast_i,
  output int          fail_count_o,
  output int          due_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = KEY_SLOTS_DEF;

  typedef struct packed {
    logic [7:0] scan_code;
    logic       extended;
    logic       unmapped;
    logic       pressed;
    logic       last_event;
  } scan_event_t;

  typedef logic [7:0] key_set_t [SLOTS];

  logic [7:0]  held_mods = '0;
  key_set_t    held_keys = '{default: '0};
  scan_event_t due_events [$];

  function automatic bit key_in_set(key_set_t keys, logic [7:0] key);
    foreach (keys[i]) begin
      if (keys[i] == key) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic scan_event_t key_event(logic [7:0] usage, logic press);
    logic [7:0] code;
    code = 8'h00;
    if (usage >= USAGE_FIRST && usage <= USAGE_LAST) code = USAGE_TABLE[usage - USAGE_FIRST];
    // no set-1 code: the raw usage goes out, flagged
    if (code == 8'h00) return {usage, 1'b0, 1'b1, press, 1'b0};
    return {code, 1'b0, 1'b0, press, 1'b0};
  endfunction

  task automatic diff_report(logic [63:0] data, logic ok);
    logic [3:0]  len;
    logic [7:0]  mods;
    key_set_t    keys;
    scan_event_t ev;
    bit          rollover;
    int          produced;
    if (!ok) return;
    len      = data[3:0];
    mods     = (len >= 1) ? data[11:4] : 8'h00;
    rollover = 1'b1;
    for (int i = 0; i < SLOTS; i++) begin
      keys[i] = (i < INPUT_SLOTS && len >= i + 3) ? data[12 + 8 * i +: 8] : 8'h00;
      if (keys[i] != USAGE_ROLLOVER) rollover = 1'b0;
    end
    // error roll-over report: dropped, stored report kept
    if (rollover) return;
    produced = 0;
    for (int b = 0; b < 8; b++) begin
      if (mods[b] != held_mods[b]) begin
        if (MOD_TABLE[b] == 8'h00) begin
          ev = {UNMAPPED_MOD + 8'(b), 1'b0, 1'b1, mods[b], 1'b0};
        end else begin
          ev = {MOD_TABLE[b], (b == MOD_RCTRL || b == MOD_RALT), 1'b0, mods[b], 1'b0};
        end
        due_events.push_back(ev);
        produced++;
      end
    end
    // each slot on its own, so duplicates give repeated events
    for (int i = 0; i < SLOTS; i++) begin
      if (held_keys[i] != 8'h00 && !key_in_set(keys, held_keys[i])) begin
        due_events.push_back(key_event(held_keys[i], 1'b0));
        produced++;
      end
    end
    for (int i = 0; i < SLOTS; i++) begin
      if (keys[i] != 8'h00 && !key_in_set(held_keys, keys[i])) begin
        due_events.push_back(key_event(keys[i], 1'b1));
        produced++;
      end
    end
    if (produced > 0) due_events[due_events.size() - 1].last_event = 1'b1;
    held_mods = mods;
    held_keys = keys;
  endtask

  task automatic check_event(scan_event_t got);
    scan_event_t want;
    if (due_events.size() == 0) begin
      $error("scancode event %02h with none expected", got.scan_code);
      fail_count_o++;
      return;
    end
    want = due_events.pop_front();
    if (got.scan_code !== want.scan_code) begin
      $error("scan_code: expected %02h, got %02h", want.scan_code, got.scan_code);
      fail_count_o++;
    end
    if (got.extended !== want.extended) begin
      $error("extended_prefix: expected %0b, got %0b", want.extended, got.extended);
      fail_count_o++;
    end
    if (got.unmapped !== want.unmapped) begin
      $error("unmapped: expected %0b, got %0b", want.unmapped, got.unmapped);
      fail_count_o++;
    end
    if (got.pressed !== want.pressed) begin
      $error("pressed: expected %0b, got %0b", want.pressed, got.pressed);
      fail_count_o++;
    end
    if (got.last_event !== want.last_event) begin
      $error("last_event: expected %0b, got %0b", want.last_event, got.last_event);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      held_mods = 8'h00;
      held_keys = '{default: '0};
      due_events.delete();
    end else begin
      // predict first so an event of the item taken at this edge finds its entry
      if (s_tvalid_i && s_tready_i) diff_report(s_tdata_i, s_tuser_i);
      if (m_tvalid_i && m_tready_i) begin
        check_event({m_tdata_i, m_tuser_i[0], m_tuser_i[1], m_tuser_i[2], m_tlast_i});
      end
    end
    due_count_o = due_events.size();
  end

endmodule

// File: dv/testbench.sv
// testbench top: drives keyboard reports, paces the event sink and gives the verdict
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_REPORTS = 340;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 50;

  bit          clk_i  = 1'b0;
  bit          rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [63:0] s_axis_tdata  = '0;
  logic        s_axis_tuser  = 1'b0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [7:0]  m_axis_tdata;
  wire  [2:0]  m_axis_tuser;
  wire         m_axis_tlast;

  int fail_count;
  int events_due;

  // sender pacing
  bit tx_eager     = 1'b0;
  int tx_phase     = 0;
  int burst_left   = 0;
  bit hold_off_req = 1'b0;

  // keyboard state for well-formed report sequences
  bit [7:0] kb_keys [6] = '{default: '0};
  bit [7:0] kb_mods     = '0;

  hid_boot_report_to_scancode_events_top DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .s_axis_tuser,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tuser,
    .m_axis_tlast
  );

  scancode_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_i   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .m_tvalid_i   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_i    (m_axis_tdata),
    .m_tuser_i    (m_axis_tuser),
    .m_tlast_i    (m_axis_tlast),
    .fail_count_o (fail_count),
    .due_count_o  (events_due)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_idle();
    if ($urandom_range(0, 5) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic bit [7:0] pick_usage();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return 8'h00;
    if (r < 9) return 8'($urandom_range(8'h04, 8'h38));
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic idle_sender(int n);
    if (n > 0) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  // keys[7:0] is slot a, keys[47:40] slot f
  task automatic send_report(bit ok, bit [3:0] len, bit [7:0] mods, bit [47:0] keys);
    int gap;
    if (tx_phase == 0) begin
      tx_eager = ($urandom_range(0, 3) == 0);
      tx_phase = $urandom_range(20, 80);
    end
    tx_phase--;
    gap = 0;
    if (burst_left > 0) burst_left--;
    else if (!tx_eager && $urandom_range(0, 2) == 0) gap = pick_idle();
    idle_sender(gap);
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = ok;
    s_axis_tdata  = {4'b0000, keys, mods, len};
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_results();
    idle_sender(1);
    while (events_due != 0) @(negedge clk_i);
  endtask

  // event sink: random stalls, calm stretches, and one long hold-off on request
  initial begin
    int  rx_wait;
    bit  rx_eager;
    int  rx_phase;
    rx_wait  = 0;
    rx_eager = 1'b0;
    rx_phase = 0;
    forever begin
      @(negedge clk_i);
      if (rx_phase == 0) begin
        rx_eager = ($urandom_range(0, 3) == 0);
        rx_phase = $urandom_range(30, 150);
      end
      rx_phase--;
      if (hold_off_req) begin
        m_axis_tready = 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_off_req = 1'b0;
      end else if (rx_wait > 0) begin
        m_axis_tready = 1'b0;
        rx_wait--;
      end else begin
        m_axis_tready = 1'b1;
        if (!rx_eager && $urandom_range(0, 2) == 0) rx_wait = pick_idle();
      end
    end
  end

  initial begin
    int        counted;
    int        kind;
    int        a;
    int        b;
    bit        hold_done;
    bit        drain_done;
    bit [3:0]  len;
    bit [7:0]  tmp;
    bit [47:0] keys;
    counted    = 0;
    hold_done  = 1'b0;
    drain_done = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_report(1'b1, 4'd8, 8'h00, 48'h00_00_00_00_00_00);
    // every modifier down including the unmapped ones, six mapped keys
    send_report(1'b1, 4'd8, 8'hFF, 48'h09_08_07_06_05_04);
    // longest run: all modifiers up, six releases, six presses
    send_report(1'b1, 4'd8, 8'h00, 48'h0F_0E_0D_0C_0B_0A);
    // error roll-over and a failed transfer, both dropped
    send_report(1'b1, 4'd8, 8'h11, 48'h01_01_01_01_01_01);
    send_report(1'b0, 4'd8, 8'hAA, 48'h38_37_36_35_34_33);
    // right ctrl and right alt need the extended prefix; length past eight
    send_report(1'b1, 4'd15, 8'h50, 48'h0F_0E_0D_0C_0B_0A);
    // slot f cut off by the length, so this is not a roll-over
    send_report(1'b1, 4'd7, 8'h50, 48'h01_01_01_01_01_01);
    // duplicated keys: old ones released per slot, new ones pressed per slot
    send_report(1'b1, 4'd8, 8'h00, 48'h00_00_1C_1C_2A_2A);
    // usages without a set-1 code
    send_report(1'b1, 4'd8, 8'h00, 48'hFF_E0_39_32_03_02);
    // length zero reads as an empty report
    send_report(1'b1, 4'd0, 8'hFF, 48'hFF_FF_FF_FF_FF_FF);
    send_report(1'b1, 4'd1, 8'h88, 48'h04_04_04_04_04_04);
    send_report(1'b1, 4'd2, 8'h08, 48'h05_05_05_05_05_05);
    send_report(1'b1, 4'd3, 8'h00, 48'h11_11_11_11_11_04);
    send_report(1'b1, 4'd9, 8'h7F, 48'h38_37_36_35_34_33);
    // same keys in other slots: nothing changes
    send_report(1'b1, 4'd8, 8'h7F, 48'h33_34_35_36_37_38);
    send_report(1'b1, 4'd8, 8'h80, 48'h00_00_00_00_00_00);
    send_report(1'b1, 4'd12, 8'hFF, 48'h01_01_01_01_01_01);
    send_report(1'b1, 4'd8, 8'h01, 48'h2C_28_2A_29_2B_39);
    send_report(1'b0, 4'd0, 8'h00, 48'h00_00_00_00_00_00);
    send_report(1'b1, 4'd4, 8'h02, 48'hFF_FF_FF_FF_31_32);
    send_report(1'b1, 4'd8, 8'h00, 48'h00_00_00_00_00_00);
    drain_results();

    while (counted < RANDOM_REPORTS) begin
      if (counted == 100 && !hold_done) begin
        // sink holds off while reports keep coming back to back
        hold_done    = 1'b1;
        hold_off_req = 1'b1;
        burst_left   = 12;
      end
      if (counted == 250 && !drain_done) begin
        drain_done = 1'b1;
        drain_results();
      end
      kind = $urandom_range(0, 19);
      if (kind < 2) begin
        send_report(1'b0, 4'($urandom_range(0, 15)), 8'($urandom()),
                    48'({$urandom(), $urandom()}));
      end else if (kind == 2) begin
        send_report(1'b1, 4'($urandom_range(8, 15)), 8'($urandom()), {6{8'h01}});
      end else if (kind < 6) begin
        send_report(1'b1, 4'($urandom_range(0, 15)), 8'($urandom()),
                    48'({$urandom(), $urandom()}));
        counted++;
      end else begin
        repeat ($urandom_range(0, 3)) kb_keys[$urandom_range(0, 5)] = pick_usage();
        if ($urandom_range(0, 9) == 0) begin
          a          = $urandom_range(0, 5);
          b          = $urandom_range(0, 5);
          tmp        = kb_keys[a];
          kb_keys[a] = kb_keys[b];
          kb_keys[b] = tmp;
        end
        if ($urandom_range(0, 19) == 0) kb_keys[$urandom_range(0, 5)] = kb_keys[$urandom_range(0, 5)];
        if ($urandom_range(0, 3) == 0) begin
          a          = $urandom_range(0, 7);
          kb_mods[a] = ~kb_mods[a];
        end
        len = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15)) : 4'd8;
        for (int i = 0; i < 6; i++) keys[8 * i +: 8] = kb_keys[i];
        send_report(1'b1, len, kb_mods, keys);
        counted++;
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && events_due == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
